>>> rtl/rotated_bitmap_color_scanout_defines.svh
// Assertion macros shared by the scan-out checker.
`ifndef ROTATED_BITMAP_COLOR_SCANOUT_DEFINES_SVH
`define ROTATED_BITMAP_COLOR_SCANOUT_DEFINES_SVH

// Check that holds in the same cycle as its condition.
`define RBCS_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("scan-out check failed");

// Check that holds in the cycle after its condition.
`define RBCS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("scan-out check failed");

`endif

>>> rtl/rbcs_pkg.sv
// Package with screen geometry, palette and shared types for the scan-out block.
`timescale 1ns / 1ps

package rbcs_pkg;

   // Screen geometry.
   localparam int SCREEN_COLUMNS = 224;
   localparam int SCREEN_ROWS    = 256;
   localparam int GROUP_COUNT    = ((SCREEN_ROWS / 8) == 0) ? 1 : (SCREEN_ROWS / 8);

   // Fixed colors and base address.
   localparam logic [13:0] BITMAP_BASE = 14'h2400;
   localparam logic [15:0] BG_COLOR    = 16'hf00f;

   // Raster position captured for one request, with the addresses of the next fetch.
   typedef struct packed {
      logic [7:0]  col;
      logic [4:0]  grp;
      logic        frame_done;
      logic [13:0] next_baddr;
      logic [10:0] next_caddr;
   } raster_type;

   // Fixed eight-entry foreground palette.
   function automatic logic [15:0] palette_color(input logic [2:0] sel);
      logic [15:0] color;
      case (sel)
         3'd0: color = 16'h088f;
         3'd1: color = 16'hff00;
         3'd2: color = 16'hf00f;
         3'd3: color = 16'hff0f;
         3'd4: color = 16'hf0f0;
         3'd5: color = 16'hfff0;
         3'd6: color = 16'hf0ff;
         3'd7: color = 16'hffff;
         default: color = BG_COLOR;
      endcase
      return color;
   endfunction

endpackage

>>> rtl/rotated_bitmap_color_scanout.sv
// Top level of the rotated bitmap scan-out with coarse color lookup.
// A taken request is captured in the holding register; its pixels then move to the output register.
// Throughput: one pixel per cycle while the output register is free, set by the bit counter
// that walks the eight bits of the held byte through the output register.
// A new request is taken in the cycle the eighth pixel moves to the output register.
// Synchronous active-high reset clears the counters and all valid flags.
`timescale 1ns / 1ps

module rotated_bitmap_color_scanout (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_bitmap_byte,
   input  logic [7:0]  req_color_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pixel_index,
   output logic [15:0] rsp_pixel_color,
   output logic        rsp_last_of_run,
   output logic        rsp_end_of_frame,
   output logic [13:0] rsp_next_bitmap_addr,
   output logic [10:0] rsp_next_color_addr
);
   import rbcs_pkg::*;

   raster_type  pos;
   raster_type  pos_ff;
   logic [7:0]  bits_ff;
   logic [2:0]  sel_ff;
   logic [2:0]  cnt_ff, cnt_in;
   logic        hold_vld_ff, hold_vld_in;
   logic        out_vld_ff, out_vld_in;
   logic        req_take;
   logic        out_free;
   logic        move;
   logic        last_bit;
   logic [7:0]  row;
   logic [15:0] flipped;
   logic [31:0] idx_wide;
   logic [15:0] pix_idx;
   logic [15:0] pix_color;

   rbcs_raster u_raster (
      .clock   (clock),
      .reset   (reset),
      .advance (req_take),
      .pos     (pos)
   );

   // Handshake: a held request moves one bit per cycle into the output register while it is free.
   always_comb begin
      out_free  = !out_vld_ff || rsp_ready;
      move      = hold_vld_ff && out_free;
      last_bit  = cnt_ff == 3'd7;
      req_ready = !hold_vld_ff || (move && last_bit);
      req_take  = req_valid && req_ready;
   end

   // Next values of the control registers.
   always_comb begin
      if (req_take) begin
         hold_vld_in = 1'b1;
         cnt_in      = 3'd0;
      end else if (move) begin
         hold_vld_in = !last_bit;
         cnt_in      = cnt_ff + 3'd1;
      end else begin
         hold_vld_in = hold_vld_ff;
         cnt_in      = cnt_ff;
      end
      out_vld_in = move || (out_vld_ff && !rsp_ready);
   end

   // Pixel position and color for the current bit.
   always_comb begin
      row       = {pos_ff.grp, cnt_ff};
      flipped   = 16'(SCREEN_ROWS - 1) - {8'd0, row};
      idx_wide  = 32'(flipped) * 32'(SCREEN_COLUMNS) + 32'(pos_ff.col);
      pix_idx   = idx_wide[15:0];
      pix_color = bits_ff[cnt_ff] ? palette_color(sel_ff) : BG_COLOR;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         cnt_ff      <= 3'd0;
      end else begin
         hold_vld_ff <= hold_vld_in;
         out_vld_ff  <= out_vld_in;
         cnt_ff      <= cnt_in;
      end
   end

   // Request holding register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         bits_ff <= req_bitmap_byte;
         sel_ff  <= req_color_byte[2:0];
         pos_ff  <= pos;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (move) begin
         rsp_pixel_index      <= pix_idx;
         rsp_pixel_color      <= pix_color;
         rsp_last_of_run      <= last_bit;
         rsp_end_of_frame     <= last_bit && pos_ff.frame_done;
         rsp_next_bitmap_addr <= pos_ff.next_baddr;
         rsp_next_color_addr  <= pos_ff.next_caddr;
      end
   end

   assign rsp_valid = out_vld_ff;

endmodule

>>> rtl/rbcs_raster.sv
// Column and row-group counters with next-fetch address generation.
`timescale 1ns / 1ps

module rbcs_raster (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   output rbcs_pkg::raster_type   pos
);
   import rbcs_pkg::*;

   logic [7:0]  col_ff, col_in;
   logic [4:0]  grp_ff, grp_in;
   logic        grp_wrap;
   logic        col_wrap;
   logic [12:0] offset;

   // Groups count inside a column; columns wrap at the end of the frame.
   always_comb begin
      grp_wrap = ({1'b0, grp_ff} + 6'd1) >= 6'(GROUP_COUNT);
      col_wrap = ({1'b0, col_ff} + 9'd1) >= 9'(SCREEN_COLUMNS);
      if (grp_wrap) begin
         grp_in = 5'd0;
         col_in = col_wrap ? 8'd0 : col_ff + 8'd1;
      end else begin
         grp_in = grp_ff + 5'd1;
         col_in = col_ff;
      end
   end

   // Addresses that the next fetch will use.
   always_comb begin
      offset         = {col_in, grp_in};
      pos.col        = col_ff;
      pos.grp        = grp_ff;
      pos.frame_done = grp_wrap && col_wrap;
      pos.next_baddr = BITMAP_BASE + {1'b0, offset};
      pos.next_caddr = {col_in[7:2], grp_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 8'd0;
         grp_ff <= 5'd0;
      end else if (advance) begin
         col_ff <= col_in;
         grp_ff <= grp_in;
      end
   end

endmodule

>>> rtl/rbcs_checker.sv
// Port-level checker for the scan-out block, bound to the top level.
`timescale 1ns / 1ps
`include "rotated_bitmap_color_scanout_defines.svh"

module rbcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_pixel_index,
   input logic        rsp_last_of_run,
   input logic        rsp_end_of_frame,
   input logic [13:0] rsp_next_bitmap_addr,
   input logic [10:0] rsp_next_color_addr
);
   import rbcs_pkg::*;

   logic        req_move;
   logic        rsp_wait;
   logic        mid_run;
   logic [15:0] idx_up;
   logic [24:0] fetch_addr;

   // Handshake events and derived values used by the checks.
   assign req_move   = req_valid && req_ready;
   assign rsp_wait   = rsp_valid && !rsp_ready;
   assign mid_run    = rsp_valid && rsp_ready && !rsp_last_of_run;
   assign idx_up     = rsp_pixel_index + 16'(SCREEN_COLUMNS);
   assign fetch_addr = {rsp_next_bitmap_addr, rsp_next_color_addr};

   // A taken request keeps the input closed in the cycle after.
   `RBCS_ASSERT_NEXT(a_req_gap, clock, reset, req_move, !req_ready)

   // A stalled result keeps its pixel position.
   `RBCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_pixel_index))

   // The frame ends only on the last pixel of a request.
   `RBCS_ASSERT_NOW(a_eof_last, clock, reset, rsp_valid && rsp_end_of_frame, rsp_last_of_run)

   // Within a request the fetch addresses stay fixed.
   `RBCS_ASSERT_NEXT(a_addr_same, clock, reset, mid_run, !rsp_valid || $stable(fetch_addr))

   // Within a request each pixel sits one screen row above the previous one.
   `RBCS_ASSERT_NEXT(a_idx_step, clock, reset, mid_run, !rsp_valid || idx_up == $past(rsp_pixel_index))

endmodule

bind rotated_bitmap_color_scanout rbcs_checker u_rbcs_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_pixel_index      (rsp_pixel_index),
   .rsp_last_of_run      (rsp_last_of_run),
   .rsp_end_of_frame     (rsp_end_of_frame),
   .rsp_next_bitmap_addr (rsp_next_bitmap_addr),
   .rsp_next_color_addr  (rsp_next_color_addr)
);

>>> tb/rotated_bitmap_color_scanout_tb.sv
// Self-checking testbench for the rotated bitmap scan-out with coarse color lookup.
`timescale 1ns / 1ps

module rotated_bitmap_color_scanout_tb;
   import rbcs_pkg::*;

   // One expected pixel as it should leave the block.
   typedef struct packed {
      logic [15:0] index;
      logic [15:0] color;
      logic        last;
      logic        eof;
      logic [13:0] baddr;
      logic [10:0] caddr;
   } pixel_type;

   // Tracks the raster position and the pixels each accepted request must produce.
   class pixel_ledger;
      logic [7:0]  column;
      logic [4:0]  group;
      logic [15:0] palette [8];
      pixel_type   pending_pixels [$];
      int          errors;

      function new();
         column  = '0;
         group   = '0;
         errors  = 0;
         palette = '{16'h088f, 16'hff00, 16'hf00f, 16'hff0f,
                     16'hf0f0, 16'hfff0, 16'hf0ff, 16'hffff};
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction

      // Expand one request into its eight pixels and step the raster position.
      function void note_request(logic [7:0] bitmap, logic [7:0] color_sel);
         logic [7:0]  next_column;
         logic [4:0]  next_group;
         logic        wrap;
         logic [15:0] ink;
         pixel_type   px;
         int          row;
         int          flat;

         wrap = (int'(group) == GROUP_COUNT - 1) && (int'(column) == SCREEN_COLUMNS - 1);
         next_group  = group;
         next_column = column;
         if (int'(group) + 1 >= GROUP_COUNT) begin
            next_group = '0;
            if (int'(column) + 1 >= SCREEN_COLUMNS) begin
               next_column = '0;
            end else begin
               next_column = column + 8'd1;
            end
         end else begin
            next_group = group + 5'd1;
         end

         // Only the low three color bits pick the ink; the rest are ignored.
         ink = palette[color_sel[2:0]];
         for (int b = 0; b < 8; b++) begin
            row      = int'(group) * 8 + b;
            flat     = (SCREEN_ROWS - 1 - row) * SCREEN_COLUMNS + int'(column);
            px.index = flat[15:0];
            px.color = bitmap[b] ? ink : 16'hf00f;
            px.last  = (b == 7);
            px.eof   = (b == 7) && wrap;
            px.baddr = BITMAP_BASE + {1'b0, next_column, next_group};
            px.caddr = {next_column[7:2], next_group};
            pending_pixels.push_back(px);
         end

         column = next_column;
         group  = next_group;
      endfunction

      function void compare_field(string name, int expected, int actual);
         if (expected != actual) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expected, actual);
            errors++;
         end
      endfunction

      // Compare one delivered pixel with the oldest one outstanding.
      function void check_pixel(logic [15:0] index, logic [15:0] color, logic last,
                                logic eof, logic [13:0] baddr, logic [10:0] caddr);
         pixel_type px;
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel: index 0x%0h color 0x%0h", index, color);
            errors++;
            return;
         end
         px = pending_pixels.pop_front();
         compare_field("pixel_index", px.index, index);
         compare_field("pixel_color", px.color, color);
         compare_field("last_of_run", px.last, last);
         compare_field("end_of_frame", px.eof, eof);
         compare_field("next_bitmap_addr", px.baddr, baddr);
         compare_field("next_color_addr", px.caddr, caddr);
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 400000;

   typedef enum int {DRAIN_FREE, DRAIN_RANDOM, DRAIN_PATTERN} drain_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_bitmap_byte;
   logic [7:0]  req_color_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_pixel_index;
   logic [15:0] rsp_pixel_color;
   logic        rsp_last_of_run;
   logic        rsp_end_of_frame;
   logic [13:0] rsp_next_bitmap_addr;
   logic [10:0] rsp_next_color_addr;

   pixel_ledger    board;
   drain_mode_type drain_mode;
   int             hold_off_cycles;

   rotated_bitmap_color_scanout uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_bitmap_byte      (req_bitmap_byte),
      .req_color_byte       (req_color_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pixel_index      (rsp_pixel_index),
      .rsp_pixel_color      (rsp_pixel_color),
      .rsp_last_of_run      (rsp_last_of_run),
      .rsp_end_of_frame     (rsp_end_of_frame),
      .rsp_next_bitmap_addr (rsp_next_bitmap_addr),
      .rsp_next_color_addr  (rsp_next_color_addr)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("rotated_bitmap_color_scanout verification failed");
      $finish;
   end

   // Offer one request and hold it until the block takes it.
   task automatic send_request(input logic [7:0] bitmap, input logic [7:0] color_sel);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_bitmap_byte <= bitmap;
      req_color_byte  <= color_sel;
      do begin
         @(posedge clock);
      end while (!req_ready);
      board.note_request(bitmap, color_sel);
   endtask

   // Leave the request line idle for the given number of cycles.
   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Wait until every outstanding pixel has been delivered.
   task automatic wait_for_drain();
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Receiver: long hold-offs on request, otherwise the current stall style.
   initial begin
      logic [15:0] pattern;
      int          tick;
      rsp_ready = 1'b0;
      pattern   = 16'hffff;
      tick      = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end else begin
            case (drain_mode)
               DRAIN_FREE: begin
                  rsp_ready <= 1'b1;
               end
               DRAIN_RANDOM: begin
                  rsp_ready <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_ready <= pattern[0];
                  pattern = {pattern[0], pattern[15:1]};
               end
            endcase
            tick++;
            if (tick % 48 == 0) begin
               pattern = 16'($urandom) | 16'h0101;
            end
            @(negedge clock);
         end
      end
   end

   // Check every pixel the block hands over.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_pixel(rsp_pixel_index, rsp_pixel_color, rsp_last_of_run,
                           rsp_end_of_frame, rsp_next_bitmap_addr, rsp_next_color_addr);
      end
   end

   // Stimulus and verdict.
   initial begin
      int sent;
      int burst;
      int gap;

      board           = new();
      drain_mode      = DRAIN_FREE;
      hold_off_cycles = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_bitmap_byte = 8'h00;
      req_color_byte  = 8'h00;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: all-clear and all-set bytes, every palette entry, single bits,
      // alternating bits, and color bytes with the unused high bits set.
      send_request(8'h00, 8'h00);
      for (int c = 0; c < 8; c++) begin
         send_request(8'hff, 8'(c));
      end
      drain_mode = DRAIN_PATTERN;
      send_request(8'h01, 8'h03);
      send_request(8'h80, 8'h04);
      send_request(8'haa, 8'h55);
      send_request(8'h55, 8'haa);
      send_request(8'hff, 8'hf8);
      send_request(8'hff, 8'hff);
      send_request(8'h00, 8'hff);
      send_request(8'h7e, 8'h81);
      idle_sender(1);
      wait_for_drain();

      // Long receiver hold-off while requests keep coming, so the block backs up.
      drain_mode      = DRAIN_FREE;
      hold_off_cycles = 150;
      for (int i = 0; i < 16; i++) begin
         send_request(8'($urandom), 8'($urandom));
      end
      idle_sender(1);
      wait_for_drain();

      // Random bursts with random gaps and changing receiver behavior.
      sent = 0;
      while (sent < 40) begin
         burst      = $urandom_range(1, 12);
         drain_mode = drain_mode_type'($urandom_range(0, 2));
         for (int i = 0; i < burst; i++) begin
            send_request(8'($urandom), 8'($urandom));
         end
         sent += burst;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            idle_sender(gap);
         end
      end

      // A short random tail.
      for (int i = 0; i < 30; i++) begin
         drain_mode = drain_mode_type'($urandom_range(0, 2));
         send_request(8'($urandom), 8'($urandom));
         if ($urandom_range(0, 2) == 0) begin
            idle_sender($urandom_range(1, 10));
         end
      end
      idle_sender(1);

      // Let everything drain, then watch a little longer for stray pixels.
      wait_for_drain();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("rotated_bitmap_color_scanout verification clean");
      end else begin
         $display("rotated_bitmap_color_scanout verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/rbcs_pkg.sv
rtl/rbcs_raster.sv
rtl/rotated_bitmap_color_scanout.sv
rtl/rbcs_checker.sv
tb/rotated_bitmap_color_scanout_tb.sv
